/* hdl/ocs_pkg.sv */
package ocs_pkg;

   localparam int DEF_MAX_SEGMENTS = 256;
   localparam int DEF_COORD_BITS   = 16;

   localparam int FIELD_BITS     = 16;
   localparam int ACTION_BITS    = 2;
   localparam int STATUS_BITS    = 3;
   localparam int COUNT_OUT_BITS = 9;
   localparam int POWER_BITS     = 4;

   localparam logic [POWER_BITS-1:0] POWER_RESET = 4'd15;

   localparam logic [ACTION_BITS-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_STORE = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_CHECK = 2'd2;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK,
      ST_DEGENERATE,
      ST_OUTSIDE,
      ST_BAD_ANGLE,
      ST_OVERLAP,
      ST_CROSSING,
      ST_FULL
   } status_type;

   typedef enum logic [2:0] {
      CLS_H,
      CLS_D45,
      CLS_V,
      CLS_D135,
      CLS_NONE
   } cls_type;

endpackage

/* hdl/octilinear_segment_checker.sv */
// Clear and store beats, and check beats that fail on the candidate alone, strobe their
// result on rsp_valid in the cycle after start is taken and never raise busy. A check beat
// that must be compared with N stored segments (N > 0) holds busy while it scans: it first
// issues the first read of the segment memory, then takes one stored segment per cycle
// through its single read port. The result is strobed in the first cycle with busy low; a
// failing stored segment ends the scan early. A new beat may be started in the same cycle
// as the strobe. The receiver cannot stall: each result is present for exactly one cycle.
// The segment memory needs no clearing after reset.
module octilinear_segment_checker #(
   parameter int MAX_SEGMENTS = ocs_pkg::DEF_MAX_SEGMENTS,
   parameter int COORD_BITS   = ocs_pkg::DEF_COORD_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ocs_pkg::ACTION_BITS-1:0]      req_action,
   input  logic [ocs_pkg::FIELD_BITS-1:0]       req_start_x,
   input  logic [ocs_pkg::FIELD_BITS-1:0]       req_start_y,
   input  logic [ocs_pkg::FIELD_BITS-1:0]       req_end_x,
   input  logic [ocs_pkg::FIELD_BITS-1:0]       req_end_y,
   output logic                                 rsp_valid,
   output logic [ocs_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [ocs_pkg::COUNT_OUT_BITS-1:0]   rsp_stored_count,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ocs_pkg::POWER_BITS-1:0]       csr_data
);
   import ocs_pkg::*;

   localparam int CW   = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
   localparam int DW   = CW + 1;
   localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
   localparam int IW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int BNDW = (1 << POWER_BITS) + 1;

   typedef struct packed {
      logic [CW-1:0] x0;
      logic [CW-1:0] y0;
      logic [CW-1:0] x1;
      logic [CW-1:0] y1;
   } seg_type;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   function automatic cls_type classify(seg_type s);
      cls_type c;
      if (s.x0 == s.x1 && s.y0 == s.y1) begin
         c = CLS_NONE;
      end else if (s.y0 == s.y1) begin
         c = CLS_H;
      end else if (s.x0 == s.x1) begin
         c = CLS_V;
      end else if (DW'(s.x1) - DW'(s.x0) == DW'(s.y1) - DW'(s.y0)) begin
         c = CLS_D45;
      end else if (DW'(s.x1) + DW'(s.y1) == DW'(s.x0) + DW'(s.y0)) begin
         c = CLS_D135;
      end else begin
         c = CLS_NONE;
      end
      return c;
   endfunction

   function automatic logic overlap(seg_type a, seg_type b, cls_type c);
      logic          key;
      logic [CW-1:0] a0, a1, b0, b1, alo, ahi, blo, bhi;
      case (c)
         CLS_H:    key = (a.y0 == b.y0);
         CLS_V:    key = (a.x0 == b.x0);
         CLS_D45:  key = (DW'(a.x0) - DW'(a.y0) == DW'(b.x0) - DW'(b.y0));
         CLS_D135: key = (DW'(a.x0) + DW'(a.y0) == DW'(b.x0) + DW'(b.y0));
         default:  key = 1'b0;
      endcase
      a0  = (c == CLS_V) ? a.y0 : a.x0;
      a1  = (c == CLS_V) ? a.y1 : a.x1;
      b0  = (c == CLS_V) ? b.y0 : b.x0;
      b1  = (c == CLS_V) ? b.y1 : b.x1;
      alo = (a0 < a1) ? a0 : a1;
      ahi = (a0 < a1) ? a1 : a0;
      blo = (b0 < b1) ? b0 : b1;
      bhi = (b0 < b1) ? b1 : b0;
      return key && (alo < bhi) && (blo < ahi);
   endfunction

   // The first argument is the rising diagonal, the second the falling one.
   function automatic logic crossing(seg_type d, seg_type e);
      logic signed [DW-1:0] a, p0, p1;
      logic        [DW-1:0] b, q0, q1;
      logic                 s45, s135;
      a    = $signed(DW'(d.x0) - DW'(d.y0));
      p0   = $signed(DW'(e.x0) - DW'(e.y0));
      p1   = $signed(DW'(e.x1) - DW'(e.y1));
      b    = DW'(e.x0) + DW'(e.y0);
      q0   = DW'(d.x0) + DW'(d.y0);
      q1   = DW'(d.x1) + DW'(d.y1);
      s45  = (p0 > a && p1 < a) || (p0 < a && p1 > a);
      s135 = (q0 > b && b > q1) || (q0 < b && b < q1);
      return s45 && s135 && (d.x0[0] ^ d.y0[0] ^ e.x0[0] ^ e.y0[0]);
   endfunction

   state_type             state_ff, state_in;
   seg_type               cand_ff, cand_in;
   cls_type               cand_cls_ff, cand_cls_in;
   logic [CNTW-1:0]       count_ff, count_in;
   logic [CNTW-1:0]       issue_ff, issue_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [POWER_BITS-1:0] power_ff, power_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   seg_type               rd_data_ff;
   seg_type               seg_mem [MAX_SEGMENTS];

   seg_type               seg_in;
   cls_type               cls_in;
   logic [BNDW-1:0]       bound;
   logic                  outside;
   logic                  mem_we;
   cls_type               st_cls;
   logic                  diag_pair;
   seg_type               diag_d, diag_e;
   logic                  hit_overlap, hit_crossing;

   always_comb begin
      seg_in.x0 = req_start_x[CW-1:0];
      seg_in.y0 = req_start_y[CW-1:0];
      seg_in.x1 = req_end_x[CW-1:0];
      seg_in.y1 = req_end_y[CW-1:0];
      cls_in    = classify(seg_in);
      bound     = BNDW'(1) << power_ff;
      outside   = (BNDW'(seg_in.x0) > bound) || (BNDW'(seg_in.y0) > bound) ||
                  (BNDW'(seg_in.x1) > bound) || (BNDW'(seg_in.y1) > bound);
   end

   always_comb begin
      st_cls       = classify(rd_data_ff);
      hit_overlap  = (cand_cls_ff == st_cls) && (st_cls != CLS_NONE) &&
                     overlap(cand_ff, rd_data_ff, cand_cls_ff);
      diag_pair    = (cand_cls_ff == CLS_D45 && st_cls == CLS_D135) ||
                     (cand_cls_ff == CLS_D135 && st_cls == CLS_D45);
      diag_d       = (cand_cls_ff == CLS_D45) ? cand_ff : rd_data_ff;
      diag_e       = (cand_cls_ff == CLS_D45) ? rd_data_ff : cand_ff;
      hit_crossing = diag_pair && crossing(diag_d, diag_e);
   end

   always_comb begin
      state_in      = state_ff;
      cand_in       = cand_ff;
      cand_cls_in   = cand_cls_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      rd_vld_in     = 1'b0;
      power_in      = power_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      if (csr_valid && csr_ready) begin
         power_in = csr_data;
      end
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_status_in = ST_OK;
               case (req_action)
                  ACT_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_STORE: begin
                     if (count_ff >= CNTW'(MAX_SEGMENTS)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  ACT_CHECK: begin
                     cand_in     = seg_in;
                     cand_cls_in = cls_in;
                     issue_in    = '0;
                     if (seg_in.x0 == seg_in.x1 && seg_in.y0 == seg_in.y1) begin
                        rsp_status_in = ST_DEGENERATE;
                        rsp_valid_in  = 1'b1;
                     end else if (outside) begin
                        rsp_status_in = ST_OUTSIDE;
                        rsp_valid_in  = 1'b1;
                     end else if (cls_in == CLS_NONE) begin
                        rsp_status_in = ST_BAD_ANGLE;
                        rsp_valid_in  = 1'b1;
                     end else if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue_ff != count_ff) begin
               issue_in  = issue_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff && (hit_overlap || hit_crossing)) begin
               rsp_status_in = hit_overlap ? ST_OVERLAP : ST_CROSSING;
               rsp_valid_in  = 1'b1;
               rd_vld_in     = 1'b0;
               state_in      = S_IDLE;
            end else if (rd_vld_ff && issue_ff == count_ff) begin
               rsp_status_in = ST_OK;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         power_ff     <= POWER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         power_ff     <= power_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff       <= cand_in;
      cand_cls_ff   <= cand_cls_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         seg_mem[count_ff[IW-1:0]] <= seg_in;
      end
      rd_data_ff <= seg_mem[issue_ff[IW-1:0]];
   end

   assign busy             = (state_ff == S_SCAN);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_stored_count = COUNT_OUT_BITS'(count_ff);

   a_accept_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted beat neither scanned nor answered");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while still scanning");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_SEGMENTS))
      else $error("segment count above store depth");

   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (issue_ff <= count_ff && count_ff != '0))
      else $error("scan index beyond stored segments");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (count_ff == CNTW'(MAX_SEGMENTS)))
      else $error("full status with room left in the store");

endmodule
